// File: rtl/tsba_pkg.sv
// ----------------------------------------------------------------------------
// tsba_pkg
// Types and codes shared by the tree split bus arbiter modules.
// ----------------------------------------------------------------------------
package tsba_pkg;

	localparam int LEVELS      = 4;
	localparam int GROUP_WIDTH = 8;
	localparam int CFG_WIDTH   = 16;

	// item kinds
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_REPLY = 1'b1;

	// reply codes
	localparam logic [1:0] REPLY_NONE = 2'd0;
	localparam logic [1:0] REPLY_ONE  = 2'd1;

	// request kinds
	localparam logic [2:0] RK_POLL   = 3'd0;
	localparam logic [2:0] RK_GROUP  = 3'd1;
	localparam logic [2:0] RK_SINGLE = 3'd2;
	localparam logic [2:0] RK_READ   = 3'd3;
	localparam logic [2:0] RK_DONE   = 3'd4;

	// phase codes
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_POLL = 2'd1;
	localparam logic [1:0] PH_SCAN = 2'd2;
	localparam logic [1:0] PH_TREE = 2'd3;

	// register indexes
	localparam logic [1:0] REG_GROUP_FIRST    = 2'd0;
	localparam logic [1:0] REG_GROUP_END      = 2'd1;
	localparam logic [1:0] REG_MESSAGE_TARGET = 2'd2;

	typedef struct packed {
		logic       kind;
		logic [1:0] reply;
	} item_t;

	typedef struct packed {
		logic [2:0]  request_kind;
		logic [2:0]  request_level;
		logic [11:0] request_address;
		logic [15:0] message_count;
	} result_t;

	typedef struct packed {
		logic [7:0]  group_first;
		logic [8:0]  group_end;
		logic [15:0] message_target;
	} cfg_t;

	typedef struct packed {
		logic [1:0]             phase;
		logic [GROUP_WIDTH-1:0] group_index;
		logic [LEVELS-1:0]      branch_bits;
		logic [1:0]             depth;
		logic [15:0]            messages;
		logic [2:0]             pending_kind;
	} state_t;

endpackage

// File: rtl/tsba_cfg.sv
// ----------------------------------------------------------------------------
// tsba_cfg
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
module tsba_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [1:0]                    cfg_index,
	input  logic [tsba_pkg::CFG_WIDTH-1:0] cfg_data,
	output tsba_pkg::cfg_t                cfg
);

	tsba_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.group_first    <= 8'd1;
			cfg_q.group_end      <= 9'd1;
			cfg_q.message_target <= 16'd0;
		end else if (cfg_wen) begin
			case (cfg_index)
				tsba_pkg::REG_GROUP_FIRST: begin
					cfg_q.group_first <= cfg_data[7:0];
				end
				tsba_pkg::REG_GROUP_END: begin
					cfg_q.group_end <= cfg_data[8:0];
				end
				tsba_pkg::REG_MESSAGE_TARGET: begin
					cfg_q.message_target <= cfg_data[15:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/tsba_step.sv
// ----------------------------------------------------------------------------
// tsba_step
// Next-state and next-request logic for one item.
// ----------------------------------------------------------------------------
module tsba_step (
	input  tsba_pkg::state_t  state,
	input  tsba_pkg::cfg_t    cfg,
	input  tsba_pkg::item_t   item,
	output tsba_pkg::state_t  state_next,
	output tsba_pkg::result_t result_next
);

	function automatic tsba_pkg::result_t mk_req(input logic [2:0] kind,
			input logic [2:0] level, input logic [11:0] addr, input logic [15:0] count);
		tsba_pkg::result_t r;
		r.request_kind    = kind;
		r.request_level   = level;
		r.request_address = addr;
		r.message_count   = count;
		return r;
	endfunction

	tsba_pkg::state_t  s;
	tsba_pkg::result_t r;
	logic              several;
	logic              reply_one;
	logic              reply_any;
	logic [15:0]       inc;
	logic              do_advance;
	logic              do_next;
	logic              do_scan;
	logic              do_end;
	logic              do_node;
	logic              found;
	logic              exhausted;
	logic [1:0]        d;
	logic [1:0]        b;
	logic [8:0]        gi_plus;
	logic [11:0]       taddr;

	always_comb begin
		s          = state;
		r          = mk_req(tsba_pkg::RK_DONE, 3'd0, 12'd0, state.messages);
		several    = item.reply[1];
		reply_one  = (item.reply == tsba_pkg::REPLY_ONE);
		reply_any  = (item.reply != tsba_pkg::REPLY_NONE);
		inc        = (state.messages != 16'hFFFF) ? state.messages + 16'd1 : state.messages;
		do_advance = 1'b0;
		do_next    = 1'b0;
		do_scan    = 1'b0;
		do_end     = 1'b0;
		do_node    = 1'b0;
		found      = 1'b0;
		exhausted  = 1'b0;
		d          = 2'd0;
		b          = 2'd0;
		gi_plus    = 9'd0;
		taddr      = 12'd0;

		if (item.kind == tsba_pkg::KIND_START) begin
			s.messages    = 16'd0;
			s.branch_bits = '0;
			s.depth       = 2'd0;
			s.group_index = '0;
			do_end        = 1'b1;
		end else begin
			case (state.pending_kind)
				tsba_pkg::RK_POLL: begin
					if (several) begin
						s.group_index = cfg.group_first;
						if ({1'b0, cfg.group_first} < cfg.group_end) begin
							do_scan = 1'b1;
						end else begin
							do_end = 1'b1;
						end
					end else if (reply_one) begin
						s.phase        = tsba_pkg::PH_POLL;
						s.pending_kind = tsba_pkg::RK_READ;
						r = mk_req(tsba_pkg::RK_READ, 3'd0, 12'd0, s.messages);
					end else begin
						do_end = 1'b1;
					end
				end
				tsba_pkg::RK_GROUP: begin
					if (state.phase == tsba_pkg::PH_SCAN) begin
						if (several) begin
							s.phase       = tsba_pkg::PH_TREE;
							s.depth       = 2'(tsba_pkg::LEVELS - 1);
							s.branch_bits = '0;
							do_node       = 1'b1;
						end else if (reply_one) begin
							s.pending_kind = tsba_pkg::RK_READ;
							r = mk_req(tsba_pkg::RK_READ, 3'd0, 12'd0, s.messages);
						end else begin
							do_next = 1'b1;
						end
					end else begin
						s.phase = tsba_pkg::PH_TREE;
						if (several) begin
							if (s.depth != 2'd0) begin
								s.depth = s.depth - 2'd1;
							end
							do_node = 1'b1;
						end else if (reply_one) begin
							s.pending_kind = tsba_pkg::RK_READ;
							r = mk_req(tsba_pkg::RK_READ, 3'd0, 12'd0, s.messages);
						end else begin
							do_advance = 1'b1;
						end
					end
				end
				tsba_pkg::RK_SINGLE: begin
					s.phase = tsba_pkg::PH_TREE;
					if (reply_any) begin
						s.messages = inc;
					end
					do_advance = 1'b1;
				end
				tsba_pkg::RK_READ: begin
					if (state.phase == tsba_pkg::PH_POLL) begin
						s.messages = inc;
						do_end     = 1'b1;
					end else if (state.phase == tsba_pkg::PH_SCAN) begin
						s.messages = inc;
						do_next    = 1'b1;
					end else begin
						s.phase = tsba_pkg::PH_TREE;
						if (reply_any) begin
							s.messages = inc;
						end
						do_advance = 1'b1;
					end
				end
				default: begin
					s.phase        = tsba_pkg::PH_IDLE;
					s.pending_kind = tsba_pkg::RK_DONE;
				end
			endcase
		end

		// walk back up the branch stack
		if (do_advance) begin
			d = s.depth;
			for (int i = 0; i < tsba_pkg::LEVELS; i++) begin
				if (!found && !exhausted) begin
					b = 2'(tsba_pkg::LEVELS - 1) - d;
					if (!s.branch_bits[b]) begin
						s.branch_bits[b] = 1'b1;
						found            = 1'b1;
					end else begin
						s.branch_bits[b] = 1'b0;
						if (d == 2'(tsba_pkg::LEVELS - 1)) begin
							exhausted = 1'b1;
						end else begin
							d = d + 2'd1;
						end
					end
				end
			end
			s.depth = d;
			do_node = found;
			do_next = exhausted;
		end

		if (do_next) begin
			gi_plus = {1'b0, s.group_index} + 9'd1;
			if (gi_plus < cfg.group_end) begin
				s.group_index = gi_plus[7:0];
				do_scan       = 1'b1;
			end else begin
				do_end = 1'b1;
			end
		end

		if (do_scan) begin
			s.phase        = tsba_pkg::PH_SCAN;
			s.branch_bits  = '0;
			s.depth        = 2'd0;
			s.pending_kind = tsba_pkg::RK_GROUP;
			r = mk_req(tsba_pkg::RK_GROUP, 3'(tsba_pkg::LEVELS), {4'd0, s.group_index},
				s.messages);
		end

		if (do_end) begin
			if (s.messages < cfg.message_target) begin
				s.phase        = tsba_pkg::PH_POLL;
				s.pending_kind = tsba_pkg::RK_POLL;
				r = mk_req(tsba_pkg::RK_POLL, 3'd0, 12'd0, s.messages);
			end else begin
				s.phase        = tsba_pkg::PH_IDLE;
				s.pending_kind = tsba_pkg::RK_DONE;
				r = mk_req(tsba_pkg::RK_DONE, 3'd0, 12'd0, s.messages);
				s.messages     = 16'd0;
			end
		end

		if (do_node) begin
			taddr = {s.branch_bits, s.group_index};
			if (s.depth == 2'd0) begin
				s.pending_kind = tsba_pkg::RK_SINGLE;
				r = mk_req(tsba_pkg::RK_SINGLE, 3'd0, taddr, s.messages);
			end else begin
				s.pending_kind = tsba_pkg::RK_GROUP;
				r = mk_req(tsba_pkg::RK_GROUP, {1'b0, s.depth}, taddr, s.messages);
			end
		end

		state_next  = s;
		result_next = r;
	end

endmodule

// File: rtl/tree_split_bus_arbiter.sv
// ----------------------------------------------------------------------------
// tree_split_bus_arbiter
// Bus master sequencer that resolves event collisions by tree splitting.
// ----------------------------------------------------------------------------
// One item is taken per clock cycle while no result waits unaccepted. An
// accepted item waits in the input register until it is loaded, when the
// sequencer state is updated and the next request is written to the result
// register, so each item passes the input register and then the result
// register before its result leaves. The state update, which walks at most
// four levels of the branch stack, is combinational and keeps the rate of one
// item per cycle. While a result waits unaccepted the input register can still
// take one item if it is empty, then the input stalls until the result leaves.
module tree_split_bus_arbiter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  tsba_pkg::item_t                item,
	output logic                           result_valid,
	input  logic                           result_ready,
	output tsba_pkg::result_t              result,
	input  logic                           cfg_wen,
	input  logic [1:0]                     cfg_index,
	input  logic [tsba_pkg::CFG_WIDTH-1:0] cfg_data
);

	tsba_pkg::cfg_t    cfg;
	tsba_pkg::state_t  state_q;
	tsba_pkg::state_t  state_next;
	tsba_pkg::result_t result_next;
	tsba_pkg::result_t result_q;
	tsba_pkg::item_t   item_s1;
	logic              valid_s1;
	logic              result_valid_q;
	logic              adv;
	logic              load;

	tsba_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tsba_step u_step (
		.state       (state_q),
		.cfg         (cfg),
		.item        (item_s1),
		.state_next  (state_next),
		.result_next (result_next)
	);

	assign adv        = !result_valid_q || result_ready;
	assign load       = valid_s1 && adv;
	assign item_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase        <= tsba_pkg::PH_IDLE;
			state_q.group_index  <= '0;
			state_q.branch_bits  <= '0;
			state_q.depth        <= 2'd0;
			state_q.messages     <= 16'd0;
			state_q.pending_kind <= tsba_pkg::RK_DONE;
		end else if (load) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result_next;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_pending_matches: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (result_q.request_kind == state_q.pending_kind))
		else $error("pending kind differs from issued request");

	a_done_iff_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> ((result_q.request_kind == tsba_pkg::RK_DONE) ==
			(state_q.phase == tsba_pkg::PH_IDLE)))
		else $error("finished request and idle phase disagree");

	a_level_group_only: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (result_q.request_level == 3'd0 ||
			result_q.request_kind == tsba_pkg::RK_GROUP))
		else $error("level set on a non-group request");

	a_idle_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == tsba_pkg::PH_IDLE) |-> (state_q.messages == 16'd0))
		else $error("message count kept while idle");

endmodule
